// ===== src/rprq_pkg.sv =====
// ----------------------------------------------------------------------------
// rprq_pkg: shared types and constants of the priority ready queue
// Queue depth, derived widths, request and status codes, sequencer states.
// ----------------------------------------------------------------------------
package rprq_pkg;

	localparam int unsigned DEPTH = 32;                  // entries held, 2..63
	localparam int unsigned IW    = $clog2(DEPTH);       // entry index width
	localparam int unsigned CW    = $clog2(DEPTH + 1);   // entry count width
	localparam int unsigned OCC_W = 6;                   // occupancy field width

	typedef enum logic [1:0] {
		FN_ENQ = 2'd0,
		FN_POP = 2'd1,
		FN_RMV = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		STS_OK     = 2'd0,
		STS_EMPTY  = 2'd1,
		STS_FULL   = 2'd2,
		STS_ABSENT = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [7:0] id;
		logic [7:0] prio;
	} entry_t;

	typedef struct packed {
		status_t          status;
		logic [7:0]       picked_id;
		logic [7:0]       picked_priority;
		logic [OCC_W-1:0] occupancy;
	} result_t;

	// handshake between sequencer and output register
	typedef struct packed {
		logic    valid;
		result_t data;
	} res_bus_t;

endpackage

// ===== src/rprq_ram.sv =====
// ----------------------------------------------------------------------------
// rprq_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rprq_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/rprq_cmp.sv =====
// ----------------------------------------------------------------------------
// rprq_cmp: shared compare unit of the scan
// Pop: take the candidate if it is first or strictly more urgent.
// Remove: take the first candidate whose id matches the key.
// ----------------------------------------------------------------------------
module rprq_cmp import rprq_pkg::*; (
	input  func_t      mode,
	input  logic       first,
	input  entry_t     cand,
	input  entry_t     best,
	input  logic [7:0] key_id,
	output logic       hit
);

	always_comb begin
		unique case (mode)
			FN_POP:  hit = first || (cand.prio > best.prio);
			FN_RMV:  hit = first && (cand.id == key_id);
			default: hit = 1'b0;
		endcase
	end

endmodule

// ===== src/rprq_ctrl.sv =====
// ----------------------------------------------------------------------------
// rprq_ctrl: sequencer of the priority ready queue
// Append, scan for the pick through one compare unit, close up the gap.
// ----------------------------------------------------------------------------
module rprq_ctrl import rprq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  func_t      req_func,
	input  logic [7:0] req_id,
	input  logic [7:0] req_prio,
	output res_bus_t   res,
	input  logic       res_take
);

	state_t          state_q, state_d;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   rd_q;
	logic [CW-1:0]   rd_dec;
	logic            vld_s1;
	logic [IW-1:0]   idx_s1;
	logic            found_q;
	logic [IW-1:0]   best_idx_q;
	entry_t          best_q;
	func_t           func_q;
	logic [7:0]      id_q;
	status_t         status_q;
	logic            accept, full, empty, issue, phase_end, hit;
	logic            mem_we;
	logic [IW-1:0]   mem_waddr;
	entry_t          mem_wdata, mem_rdata;

	assign accept = req_valid && req_ready;
	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);
	assign rd_dec = rd_q - CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		res.valid = 1'b0;
		res.data  = '{
			status:          status_q,
			picked_id:       best_q.id,
			picked_priority: best_q.prio,
			occupancy:       OCC_W'(count_q)
		};
		issue     = 1'b0;
		phase_end = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if ((req_func == FN_POP || req_func == FN_RMV) && !empty) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_SCAN: begin
				issue     = (rd_q < count_q);
				phase_end = !issue && !vld_s1;
				if (phase_end) begin
					state_d = found_q ? S_SHIFT : S_DONE;
				end
			end
			S_SHIFT: begin
				issue     = (rd_q < count_q);
				phase_end = !issue && !vld_s1;
				if (phase_end) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				res.valid = 1'b1;
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			vld_s1  <= 1'b0;
			rd_q    <= '0;
			found_q <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if (accept) begin
				rd_q    <= '0;
				found_q <= 1'b0;
				if (req_func == FN_ENQ && !full) begin
					count_q <= count_q + CW'(1);
				end
			end else if (issue) begin
				rd_q <= rd_q + CW'(1);
			end else if (state_q == S_SCAN && phase_end && found_q) begin
				rd_q <= CW'(best_idx_q) + CW'(1);
			end
			if (state_q == S_SCAN && vld_s1 && hit) begin
				found_q <= 1'b1;
			end
			if (state_q == S_SHIFT && phase_end) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// request and pick payload
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= req_func;
			id_q   <= req_id;
			best_q <= '0;
			case (req_func)
				FN_ENQ:  status_q <= full ? STS_FULL : STS_OK;
				FN_POP:  status_q <= empty ? STS_EMPTY : STS_OK;
				FN_RMV:  status_q <= empty ? STS_ABSENT : STS_OK;
				default: status_q <= STS_OK;
			endcase
		end
		if (issue) begin
			idx_s1 <= (state_q == S_SCAN) ? rd_q[IW-1:0] : rd_dec[IW-1:0];
		end
		if (state_q == S_SCAN && vld_s1 && hit) begin
			best_q     <= mem_rdata;
			best_idx_q <= idx_s1;
		end
		if (state_q == S_SCAN && phase_end && !found_q) begin
			status_q <= STS_ABSENT;
		end
	end

	rprq_cmp u_cmp (
		.mode   (func_q),
		.first  (!found_q),
		.cand   (mem_rdata),
		.best   (best_q),
		.key_id (id_q),
		.hit    (hit)
	);

	// append on enqueue, close up one slot per cycle while shifting
	always_comb begin
		if (state_q == S_SHIFT) begin
			mem_we    = vld_s1;
			mem_waddr = idx_s1;
			mem_wdata = mem_rdata;
		end else begin
			mem_we    = accept && (req_func == FN_ENQ) && !full;
			mem_waddr = count_q[IW-1:0];
			mem_wdata = '{id: req_id, prio: req_prio};
		end
	end

	rprq_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (rd_q[IW-1:0]),
		.rdata (mem_rdata)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_shift_drops_one: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT && phase_end) |=> (count_q == $past(count_q) - CW'(1)))
		else $error("shift did not drop exactly one entry");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && vld_s1) |-> (CW'(idx_s1) < count_q))
		else $error("scan read beyond valid entries");

	a_pick_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT) |-> (found_q && CW'(best_idx_q) < count_q))
		else $error("shift without a valid pick");

endmodule

// ===== src/priority_ready_queue_top.sv =====
// ----------------------------------------------------------------------------
// priority_ready_queue_top: thread scheduler ready queue
// Stable priority queue: enqueue at the back, pop the most urgent (earliest
// among equals), remove by id. One status word per request word.
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata (low bit up)                          tuser
//  s_*      in   thread_id[7:0], priority_req[15:8]          func[1:0]
//  m_*      out  picked_id[7:0], picked_priority[15:8],      status[1:0]
//                occupancy[21:16], zero pad[23:22]
//
//  Enqueue, a rejected request or an unused code goes from accept straight to the
//  done state. Pop / remove scan every held entry (one read per entry, through
//  the registered RAM read and the compare unit). A pick at index k then moves
//  each entry behind it down one slot; both passes are set by the single RAM
//  read port. Every result then passes the done state and the output register.
//  Reset clears the entry count and the control state; entry contents need no clearing.
//  s_tready is high only while the sequencer idles; a finished result waits in
//  the output register, so the next word is taken even while m_tready is low.
// ----------------------------------------------------------------------------
module priority_ready_queue_top import rprq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // thread_id, priority_req
	input  logic [1:0]  s_tuser,   // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // picked_id, picked_priority, occupancy
	output logic [1:0]  m_tuser    // status
);

	res_bus_t res;
	result_t  out_q;
	logic     m_valid_q;
	logic     res_take;

	// take a result when the output register is empty or being drained
	assign res_take = !m_valid_q || m_tready;

	rprq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req_func  (func_t'(s_tuser)),
		.req_id    (s_tdata[7:0]),
		.req_prio  (s_tdata[15:8]),
		.res       (res),
		.res_take  (res_take)
	);

	// output register: hold the word until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_take) begin
			m_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res.valid) begin
			out_q <= res.data;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {2'b00, out_q.occupancy, out_q.picked_priority, out_q.picked_id};

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: priority ready queue, stream level check
// A directed table walks the corner cases: empty, absent id, unused code, ties
// and duplicate ids. Phased random traffic follows: fill, drain and a blend,
// so the queue runs full and empty many times. Both stream sides idle at
// random. Every result word is checked against its table row or a queue model kept here.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rprq_pkg::*;

	// func code 3 has no meaning; the block must answer ok and change nothing
	localparam logic [1:0]  FN_UNUSED     = 2'd3;
	localparam int unsigned DIRECTED_ROWS = 20;
	localparam int unsigned RANDOM_WORDS  = 800;
	localparam int unsigned PHASE_LEN     = 60;     // words per traffic mix
	localparam int unsigned STEADY_FROM   = 400;    // no idling on either side
	localparam int unsigned STEADY_TO     = 520;    //   for these random words
	localparam int unsigned IDLE_PCT      = 21;
	localparam int unsigned SETTLE_CYCLES = 4 * DEPTH + 16;  // > scan + close-up
	localparam int unsigned CYCLE_LIMIT   = 400_000;

	typedef enum logic [1:0] {
		MIX_FILL,
		MIX_DRAIN,
		MIX_BLEND
	} traffic_mix_t;

	// one row of the directed table; want is used only where typed is set
	typedef struct packed {
		logic [1:0] fn;
		logic [7:0] id;
		logic [7:0] prio;
		logic       typed;
		result_t    want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;    // thread_id, priority_req
	logic [1:0]  s_tuser;    // func
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;    // picked_id, picked_priority, occupancy, zero pad
	logic [1:0]  m_tuser;    // status

	// model of the queue contents, oldest arrival at index 0
	entry_t      ready_entries[$];
	// results owed by the block, oldest first
	result_t     expected_results[$];
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	bit          steady = 1'b0;
	stim_row_t   directed_rows [DIRECTED_ROWS];

	priority_ready_queue_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Apply one request to the queue model and return the result word it owes.
	// Pop takes the first entry of highest priority, so ties go to the earliest
	// arrival; remove takes the earliest entry with a matching id. Deleting
	// from the model queue closes up the entries behind, as the block does.
	function automatic result_t queue_step(input logic [1:0] fn, input logic [7:0] id,
			input logic [7:0] prio);
		result_t res;
		int      pick;
		res = '0;
		res.status = STS_OK;
		pick = -1;
		case (fn)
			FN_ENQ: begin
				if (ready_entries.size() >= DEPTH)
					res.status = STS_FULL;
				else
					ready_entries.push_back(entry_t'{id, prio});
			end
			FN_POP: begin
				if (ready_entries.size() == 0) begin
					res.status = STS_EMPTY;
				end else begin
					pick = 0;
					for (int i = 1; i < ready_entries.size(); i++)
						if (ready_entries[i].prio > ready_entries[pick].prio)
							pick = i;
				end
			end
			FN_RMV: begin
				for (int i = 0; i < ready_entries.size(); i++)
					if (pick < 0 && ready_entries[i].id == id)
						pick = i;
				if (pick < 0)
					res.status = STS_ABSENT;
			end
			default: ;   // unused code: nothing changes
		endcase
		if (pick >= 0) begin
			res.picked_id       = ready_entries[pick].id;
			res.picked_priority = ready_entries[pick].prio;
			ready_entries.delete(pick);
		end
		res.occupancy = OCC_W'(ready_entries.size());
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		error_count++;
		$display("[%0t] %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
	endtask

	// Compare one accepted result word with the oldest owed result.
	task automatic check_result(input logic [23:0] word, input logic [1:0] sts);
		result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch("result word with nothing owed", {6'd0, sts, word}, '0);
			return;
		end
		want = expected_results.pop_front();
		if (sts !== want.status)
			report_mismatch("status", 32'(sts), 32'(want.status));
		if (word[7:0] !== want.picked_id)
			report_mismatch("picked_id", 32'(word[7:0]), 32'(want.picked_id));
		if (word[15:8] !== want.picked_priority)
			report_mismatch("picked_priority", 32'(word[15:8]),
				32'(want.picked_priority));
		if (word[21:16] !== want.occupancy)
			report_mismatch("occupancy", 32'(word[21:16]), 32'(want.occupancy));
	endtask

	// Offer one request word and hold it until the block takes it. Valid is
	// left high on return; the next call either lowers it for a gap or puts
	// the next word straight on the bus, so it is assigned once per edge.
	task automatic push_word(input logic [1:0] fn, input logic [7:0] id,
			input logic [7:0] prio, input logic typed, input result_t want);
		result_t predicted;
		bit      fire;
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {prio, id};
		s_tuser  <= fn;
		// sample ready at the falling edge ahead of the edge that takes the word
		do begin
			@(negedge clk);
			fire = (s_tready === 1'b1);
			@(posedge clk);
		end while (!fire);
		predicted = queue_step(fn, id, prio);
		expected_results.push_back(typed ? want : predicted);
	endtask

	// Result side: stall at random, take a word on each ready and valid edge.
	initial begin : result_sink
		logic [23:0] word;
		logic [1:0]  sts;
		bit          got;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			got  = (m_tvalid === 1'b1) && m_tready;
			word = m_tdata;
			sts  = m_tuser;
			@(posedge clk);
			if (got)
				check_result(word, sts);
			m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Watchdog: a run that stalls past the limit fails.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	initial begin : stimulus
		traffic_mix_t mix;
		logic [1:0]   fn;
		logic [7:0]   id;
		logic [7:0]   prio;
		int unsigned  roll;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;

		// fn, id, prio, typed, {status, picked_id, picked_priority, occupancy}
		directed_rows = '{
			// empty queue straight after reset
			'{FN_POP,    8'h00, 8'h00, 1'b1, '{STS_EMPTY,  8'h00, 8'h00, 6'd0}},
			'{FN_RMV,    8'h00, 8'h00, 1'b1, '{STS_ABSENT, 8'h00, 8'h00, 6'd0}},
			'{FN_UNUSED, 8'hff, 8'hff, 1'b1, '{STS_OK,     8'h00, 8'h00, 6'd0}},
			// extremes of id and priority, two entries tied at the top
			'{FN_ENQ,    8'hff, 8'h00, 1'b1, '{STS_OK,     8'h00, 8'h00, 6'd1}},
			'{FN_ENQ,    8'h00, 8'hff, 1'b1, '{STS_OK,     8'h00, 8'h00, 6'd2}},
			'{FN_ENQ,    8'haa, 8'h55, 1'b1, '{STS_OK,     8'h00, 8'h00, 6'd3}},
			'{FN_ENQ,    8'h55, 8'hff, 1'b1, '{STS_OK,     8'h00, 8'h00, 6'd4}},
			'{FN_UNUSED, 8'h00, 8'h00, 1'b1, '{STS_OK,     8'h00, 8'h00, 6'd4}},
			// tie on priority: earliest arrival leaves first; pop ignores id
			'{FN_POP,    8'h3c, 8'hc3, 1'b1, '{STS_OK,     8'h00, 8'hff, 6'd3}},
			'{FN_RMV,    8'h77, 8'h00, 1'b1, '{STS_ABSENT, 8'h00, 8'h00, 6'd3}},
			// duplicate id: remove takes the earlier one
			'{FN_ENQ,    8'haa, 8'h10, 1'b1, '{STS_OK,     8'h00, 8'h00, 6'd4}},
			'{FN_RMV,    8'haa, 8'h00, 1'b1, '{STS_OK,     8'haa, 8'h55, 6'd3}},
			'{FN_POP,    8'h00, 8'h00, 1'b0, '0},
			'{FN_POP,    8'h00, 8'h00, 1'b0, '0},
			'{FN_RMV,    8'hff, 8'h00, 1'b0, '0},
			'{FN_POP,    8'h00, 8'h00, 1'b1, '{STS_EMPTY,  8'h00, 8'h00, 6'd0}},
			// remove from the back, then pop the lone entry
			'{FN_ENQ,    8'h81, 8'h80, 1'b0, '0},
			'{FN_ENQ,    8'h7e, 8'h7f, 1'b0, '0},
			'{FN_RMV,    8'h7e, 8'h00, 1'b0, '0},
			'{FN_POP,    8'h00, 8'h00, 1'b0, '0}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r])
			push_word(directed_rows[r].fn, directed_rows[r].id, directed_rows[r].prio,
				directed_rows[r].typed, directed_rows[r].want);

		// Random traffic in phases: fill runs the queue into full, drain
		// empties it, blend keeps it in the middle. Most removes name an id
		// that is held; a small id pool makes duplicates, a small priority
		// pool makes ties.
		for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
			mix    = traffic_mix_t'((n / PHASE_LEN) % 3);
			steady = (n >= STEADY_FROM && n < STEADY_TO);
			roll   = $urandom_range(99);
			if (roll < 3) begin
				fn = FN_UNUSED;
			end else begin
				case (mix)
					MIX_FILL:  fn = (roll < 90) ? FN_ENQ : ((roll < 95) ? FN_POP : FN_RMV);
					MIX_DRAIN: fn = (roll < 10) ? FN_ENQ : ((roll < 55) ? FN_POP : FN_RMV);
					default:   fn = (roll < 50) ? FN_ENQ : ((roll < 75) ? FN_POP : FN_RMV);
				endcase
			end

			if (fn == FN_RMV && ready_entries.size() > 0 && $urandom_range(99) < 80)
				id = ready_entries[$urandom_range(ready_entries.size() - 1)].id;
			else if ($urandom_range(1) == 1)
				id = 8'($urandom_range(7));
			else
				id = 8'($urandom_range(255));

			roll = $urandom_range(9);
			if (roll < 4)
				prio = 8'($urandom_range(3));
			else if (roll == 4)
				prio = ($urandom_range(1) == 1) ? 8'hff : 8'h00;
			else
				prio = 8'($urandom_range(255));

			push_word(fn, id, prio, 1'b0, '0);
		end
		steady = 1'b0;
		s_tvalid <= 1'b0;

		// wait for every owed word, then give a late extra word time to show
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
